### hdl/rsc_pkg.sv
`timescale 1ns / 1ps
// rsc_pkg: shared types and constants of the reverse polish stack calculator
// used by rsc_cell, rsc_divider and rpn_stack_calculator_top

package rsc_pkg;

  // value format: signed q16.16
  localparam int VALUE_W = 32;
  localparam int FRAC_W = 16;
  localparam int FUNC_W = 4;
  localparam int DEPTH_W = 8;

  // default number of stack cells
  localparam int STACK_DEPTH_DEF = 128;

  // iterative divider: one quotient bit per step
  localparam int DIV_STEPS = VALUE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] Q_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // function codes carried with each input beat
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH  = 4'd0,
    FN_ADD   = 4'd1,
    FN_SUB   = 4'd2,
    FN_MUL   = 4'd3,
    FN_DIV   = 4'd4,
    FN_MOD   = 4'd5,
    FN_CLEAR = 4'd6,
    FN_SWAP  = 4'd7,
    FN_DROP  = 4'd8,
    FN_PEEK  = 4'd9
  } func_t;

  // what a stack cell loads this cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_SHIFT = 2'd1,  // take the neighbor above (push direction)
    CELL_PULL1 = 2'd2,  // take the neighbor one below
    CELL_PULL2 = 2'd3   // take the neighbor two below
  } cell_op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_SAT,
    ST_DIV_RUN,
    ST_DIV_FIN,
    ST_APPLY,
    ST_REPORT
  } state_t;

  // divider start request
  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] rem_init;
    logic [VALUE_W-1:0] dividend;
    logic [VALUE_W-1:0] divisor;
  } div_req_t;

  // divider answer
  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [VALUE_W-1:0] rem;
  } div_rsp_t;

endpackage

### hdl/rsc_cell.sv
`timescale 1ns / 1ps
// rsc_cell: one entry of the shifting stack, trading values with its neighbors
// depends on rsc_pkg

module rsc_cell (
  input  logic                          clk,
  input  rsc_pkg::cell_op_t             op,
  input  logic [rsc_pkg::VALUE_W-1:0]   from_up,
  input  logic [rsc_pkg::VALUE_W-1:0]   from_down1,
  input  logic [rsc_pkg::VALUE_W-1:0]   from_down2,
  output logic [rsc_pkg::VALUE_W-1:0]   value
);

  // entry register, contents are meaningful only below the fill count
  always_ff @(posedge clk) begin
    case (op)
      rsc_pkg::CELL_SHIFT: value <= from_up;
      rsc_pkg::CELL_PULL1: value <= from_down1;
      rsc_pkg::CELL_PULL2: value <= from_down2;
      default:             value <= value;
    endcase
  end

endmodule

### hdl/rsc_divider.sv
`timescale 1ns / 1ps
// rsc_divider: unsigned restoring divider, one quotient bit per cycle
// depends on rsc_pkg

module rsc_divider (
  input  logic              clk,
  input  logic              rst,
  input  rsc_pkg::div_req_t req,
  output rsc_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [rsc_pkg::DIV_CNT_W-1:0]     step;
  logic [rsc_pkg::VALUE_W-1:0]       rem;
  logic [rsc_pkg::VALUE_W-1:0]       dvd;
  logic [rsc_pkg::VALUE_W-1:0]       dsr;
  logic [rsc_pkg::VALUE_W:0]         trial;
  logic                              fits;
  logic [rsc_pkg::VALUE_W-1:0]       rem_next;

  // one shift and trial subtract
  always_comb begin
    trial    = {rem, dvd[rsc_pkg::VALUE_W-1]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? rsc_pkg::VALUE_W'(trial - {1'b0, dsr})
                    : trial[rsc_pkg::VALUE_W-1:0];
  end

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == rsc_pkg::DIV_CNT_W'(rsc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[rsc_pkg::VALUE_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;

endmodule

### hdl/rpn_stack_calculator_top.sv
`timescale 1ns / 1ps
// rpn_stack_calculator_top: reverse polish calculator on signed q16.16 values
// depends on rsc_pkg, rsc_cell and rsc_divider
//
// Input beats on s_axis: s_axis_tuser carries the function code (push, add,
// sub, mul, div, mod, clear, swap, drop, peek), s_axis_tdata the operand that
// a push places on the stack. Each input beat gives exactly one m_axis beat:
// the top of the stack (0 when empty), the depth and the underflow, overflow
// and zero divide flags. The stack is a row of STACK_DEPTH cells; push and pop
// move every entry one or two cells along the row at once.
// Timing: one item at a time. Each item goes from ST_START through ST_APPLY to
// ST_REPORT; mul adds ST_MUL_SAT (multiply, then round and saturate), and div
// and mod add ST_DIV_RUN and ST_DIV_FIN unless they skip the divider (zero
// divisor or a div that saturates); the divider makes one quotient bit per
// cycle over 32 steps. s_axis_tready rises again in the cycle after the
// result is loaded. The result sits in an output register, so the next item is
// accepted and worked on while the previous result waits for m_axis_tready;
// a second result waits inside the block until the register is free.
// Reset empties the stack and drops m_axis_tvalid; cells are not cleared.

module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] operand_value
  input  logic [3:0]  s_axis_tuser,   // [3:0] func
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [31:0] top_value, [39:32] depth,
                                      // [40] underflow, [41] overflow,
                                      // [42] zero_divide, [47:43] zero
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int VW = rsc_pkg::VALUE_W;
  localparam int FW = rsc_pkg::FRAC_W;

  rsc_pkg::state_t   state;
  rsc_pkg::state_t   state_next;
  rsc_pkg::func_t    func_q;
  logic [VW-1:0]     opnd_q;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [VW-1:0]     res;
  logic signed [2*VW-1:0] prod;
  logic              zero_q;
  logic              neg_q;
  logic              asign_q;
  logic              under;
  logic              under_next;
  logic              over;
  logic              over_next;
  logic              zdiv;
  logic              zdiv_next;
  logic              out_load;

  // stack row
  logic [VW-1:0]       cell_q [STACK_DEPTH];
  rsc_pkg::cell_op_t   op0;
  rsc_pkg::cell_op_t   op1;
  rsc_pkg::cell_op_t   oprest;
  logic [VW-1:0]       top_in;
  logic [VW-1:0]       cell1_in;

  // operands as popped: b from the top, a below it, 0 when missing
  logic signed [VW-1:0] a_val;
  logic signed [VW-1:0] b_val;
  logic [VW-1:0]        a_mag;
  logic [VW-1:0]        b_mag;
  logic                 few;
  logic                 zero_now;
  logic                 div_sat;
  logic [VW:0]          sum;
  logic [VW-1:0]        sum_sat;
  logic [VW-1:0]        quot_neg;

  rsc_pkg::div_req_t  dreq;
  rsc_pkg::div_rsp_t  drsp;

  assign few   = cnt < CNT_W'(2);
  assign b_val = (cnt != '0) ? cell_q[0] : '0;
  assign a_val = few ? '0 : cell_q[1];
  assign a_mag = a_val[VW-1] ? VW'(-a_val) : VW'(a_val);
  assign b_mag = b_val[VW-1] ? VW'(-b_val) : VW'(b_val);

  // zero divisor: whole value for div, integer part for mod
  assign zero_now = (func_q == rsc_pkg::FN_DIV) ? (b_val == '0)
                                                : (b_mag[VW-1:FW] == '0);
  // quotient would need more than 32 bits
  assign div_sat = VW'(a_mag[VW-1:FW]) >= b_mag;

  // saturating add and sub
  always_comb begin
    if (func_q == rsc_pkg::FN_SUB) begin
      sum = {a_val[VW-1], a_val} - {b_val[VW-1], b_val};
    end else begin
      sum = {a_val[VW-1], a_val} + {b_val[VW-1], b_val};
    end
    if (sum[VW] != sum[VW-1]) begin
      sum_sat = sum[VW] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
    end else begin
      sum_sat = sum[VW-1:0];
    end
  end

  assign quot_neg = VW'(-drsp.quot);

  // divider request, issued from the start state
  always_comb begin
    dreq.start = 1'b0;
    if (func_q == rsc_pkg::FN_DIV) begin
      dreq.rem_init = VW'(a_mag[VW-1:FW]);
      dreq.dividend = {a_mag[FW-1:0], {FW{1'b0}}};
      dreq.divisor  = b_mag;
    end else begin
      dreq.rem_init = '0;
      dreq.dividend = VW'(a_mag[VW-1:FW]);
      dreq.divisor  = VW'(b_mag[VW-1:FW]);
    end
    if (state == rsc_pkg::ST_START && !zero_now &&
        (func_q == rsc_pkg::FN_MOD || (func_q == rsc_pkg::FN_DIV && !div_sat))) begin
      dreq.start = 1'b1;
    end
  end

  rsc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // sequencer: next state, stack moves and flags
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    op0           = rsc_pkg::CELL_HOLD;
    op1           = rsc_pkg::CELL_HOLD;
    oprest        = rsc_pkg::CELL_HOLD;
    top_in        = res;
    cell1_in      = cell_q[0];
    cnt_next      = cnt;
    under_next    = under;
    over_next     = over;
    zdiv_next     = zdiv;
    unique case (state)
      rsc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = rsc_pkg::ST_START;
        end
      end
      rsc_pkg::ST_START: begin
        if (func_q == rsc_pkg::FN_MUL) begin
          state_next = rsc_pkg::ST_MUL_SAT;
        end else if (dreq.start) begin
          state_next = rsc_pkg::ST_DIV_RUN;
        end else begin
          state_next = rsc_pkg::ST_APPLY;
        end
      end
      rsc_pkg::ST_MUL_SAT: begin
        state_next = rsc_pkg::ST_APPLY;
      end
      rsc_pkg::ST_DIV_RUN: begin
        if (drsp.done) begin
          state_next = rsc_pkg::ST_DIV_FIN;
        end
      end
      rsc_pkg::ST_DIV_FIN: begin
        state_next = rsc_pkg::ST_APPLY;
      end
      rsc_pkg::ST_APPLY: begin
        state_next = rsc_pkg::ST_REPORT;
        under_next = 1'b0;
        over_next  = 1'b0;
        zdiv_next  = 1'b0;
        case (func_q)
          rsc_pkg::FN_PUSH: begin
            if (cnt == CNT_W'(STACK_DEPTH)) begin
              over_next = 1'b1;
            end else begin
              op0      = rsc_pkg::CELL_SHIFT;
              op1      = rsc_pkg::CELL_SHIFT;
              oprest   = rsc_pkg::CELL_SHIFT;
              top_in   = opnd_q;
              cnt_next = cnt + 1'b1;
            end
          end
          rsc_pkg::FN_ADD, rsc_pkg::FN_SUB, rsc_pkg::FN_MUL,
          rsc_pkg::FN_DIV, rsc_pkg::FN_MOD: begin
            under_next = few;
            if ((func_q == rsc_pkg::FN_DIV || func_q == rsc_pkg::FN_MOD) && zero_q) begin
              // both operands dropped, nothing pushed
              zdiv_next = 1'b1;
              op0       = rsc_pkg::CELL_PULL2;
              op1       = rsc_pkg::CELL_PULL2;
              oprest    = rsc_pkg::CELL_PULL2;
              cnt_next  = few ? '0 : cnt - CNT_W'(2);
            end else begin
              op0      = rsc_pkg::CELL_SHIFT;
              op1      = rsc_pkg::CELL_PULL1;
              oprest   = rsc_pkg::CELL_PULL1;
              top_in   = (func_q == rsc_pkg::FN_ADD || func_q == rsc_pkg::FN_SUB)
                         ? sum_sat : res;
              cnt_next = few ? CNT_W'(1) : cnt - 1'b1;
            end
          end
          rsc_pkg::FN_CLEAR: begin
            cnt_next = '0;
          end
          rsc_pkg::FN_SWAP: begin
            under_next = few;
            op0        = rsc_pkg::CELL_SHIFT;
            op1        = rsc_pkg::CELL_SHIFT;
            top_in     = a_val;
            cell1_in   = b_val;
            cnt_next   = few ? CNT_W'(2) : cnt;
          end
          rsc_pkg::FN_DROP: begin
            if (cnt == '0) begin
              under_next = 1'b1;
            end else begin
              op0      = rsc_pkg::CELL_PULL1;
              op1      = rsc_pkg::CELL_PULL1;
              oprest   = rsc_pkg::CELL_PULL1;
              cnt_next = cnt - 1'b1;
            end
          end
          rsc_pkg::FN_PEEK: begin
            under_next = (cnt == '0);
          end
          default: begin
          end
        endcase
      end
      rsc_pkg::ST_REPORT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = rsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsc_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsc_pkg::ST_IDLE;
      cnt   <= '0;
      under <= 1'b0;
      over  <= 1'b0;
      zdiv  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      under <= under_next;
      over  <= over_next;
      zdiv  <= zdiv_next;
    end
  end

  // input capture and arithmetic results
  always_ff @(posedge clk) begin
    if (state == rsc_pkg::ST_IDLE && s_axis_tvalid) begin
      func_q <= rsc_pkg::func_t'(s_axis_tuser);
      opnd_q <= s_axis_tdata;
    end
    if (state == rsc_pkg::ST_START) begin
      prod    <= (2*VW)'(a_val) * (2*VW)'(b_val);
      zero_q  <= zero_now;
      neg_q   <= a_val[VW-1] ^ b_val[VW-1];
      asign_q <= a_val[VW-1];
      res     <= (a_val[VW-1] ^ b_val[VW-1]) ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
    end
    // product shifted down by the fraction width, floor rounding
    if (state == rsc_pkg::ST_MUL_SAT) begin
      if (prod[2*VW-1:VW+FW-1] == '0 || prod[2*VW-1:VW+FW-1] == '1) begin
        res <= prod[VW+FW-1:FW];
      end else begin
        res <= prod[2*VW-1] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
      end
    end
    // sign and range of the divider answer
    if (state == rsc_pkg::ST_DIV_FIN) begin
      if (func_q == rsc_pkg::FN_MOD) begin
        res <= asign_q ? VW'(-{drsp.rem[VW-FW-1:0], {FW{1'b0}}})
                       : {drsp.rem[VW-FW-1:0], {FW{1'b0}}};
      end else if (neg_q) begin
        res <= (drsp.quot > rsc_pkg::Q_MIN) ? rsc_pkg::Q_MIN : quot_neg;
      end else begin
        res <= drsp.quot[VW-1] ? rsc_pkg::Q_MAX : drsp.quot;
      end
    end
  end

  // row of stack cells, cell 0 is the top
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [VW-1:0]     up_d;
    logic [VW-1:0]     dn1_d;
    logic [VW-1:0]     dn2_d;
    rsc_pkg::cell_op_t op_d;
    if (i == 0) begin : g_first
      assign up_d = top_in;
      assign op_d = op0;
    end else if (i == 1) begin : g_second
      assign up_d = cell1_in;
      assign op_d = op1;
    end else begin : g_rest
      assign up_d = cell_q[i-1];
      assign op_d = oprest;
    end
    if (i + 1 < STACK_DEPTH) begin : g_dn1
      assign dn1_d = cell_q[i+1];
    end else begin : g_dn1_end
      assign dn1_d = '0;
    end
    if (i + 2 < STACK_DEPTH) begin : g_dn2
      assign dn2_d = cell_q[i+2];
    end else begin : g_dn2_end
      assign dn2_d = '0;
    end
    rsc_cell u_cell (
      .clk        (clk),
      .op         (op_d),
      .from_up    (up_d),
      .from_down1 (dn1_d),
      .from_down2 (dn2_d),
      .value      (cell_q[i])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {5'b0, zdiv, over, under, rsc_pkg::DEPTH_W'(cnt),
                       (cnt != '0) ? cell_q[0] : {VW{1'b0}}};
    end
  end

endmodule
